@@ design/smjc_pkg.sv @@
// Shared types and codes for the sorted merge join classifier.
package smjc_pkg;

    localparam int unsigned OUT_KEY_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        CAT_ONLY_FIRST  = 2'd0,
        CAT_BOTH        = 2'd1,
        CAT_ONLY_SECOND = 2'd2,
        CAT_EMPTY       = 2'd3
    } category_t;

    typedef enum logic [1:0] {
        REG_COMPARE_MASK     = 2'd0,
        REG_EMIT_ONLY_FIRST  = 2'd1,
        REG_EMIT_BOTH        = 2'd2,
        REG_EMIT_ONLY_SECOND = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

endpackage

@@ design/sorted_merge_join_classifier_unit.sv @@
// Sorted merge join classifier: list loading, two-pointer walk, result output.
// Loading: one input transaction per cycle; s_ready is high only while loading.
// Walk: starts on the transaction that completes the second list; each step is a list
//   read, then the shared masked comparator, which can stall for a free output slot;
//   c1+c2 steps at most, plus a closing read and a flush state before the next load.
// The final result is held back one slot so its last flag is known; m_ready stalls can hold the walk and flush.
// Reset (aresetn, synchronous, active low) clears the run and loads register defaults.
module sorted_merge_join_classifier_unit #(
    parameter int LIST_DEPTH = 32,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smjc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [smjc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [smjc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [smjc_pkg::OUT_KEY_W-1:0]    s_key_in,
    input  logic                              s_list_select,
    input  logic                              s_has_key,
    input  logic                              s_list_last,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_category,
    output logic [smjc_pkg::OUT_KEY_W-1:0]    m_key_first,
    output logic [smjc_pkg::OUT_KEY_W-1:0]    m_key_second,
    output logic                              m_overflow,
    output logic                              m_last
);
    import smjc_pkg::*;

    // stored key width: bits above 32 never reach the ports or the compare mask
    localparam int SW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    state_t state_reg, state_next;

    logic [31:0]   mask_reg;
    logic          emit_first_reg, emit_both_reg, emit_second_reg;

    logic [SW-1:0] first_list_reg  [LIST_DEPTH];
    logic [SW-1:0] second_list_reg [LIST_DEPTH];
    logic [CW-1:0] first_count_reg, second_count_reg;
    logic          first_done_reg, second_done_reg, dropped_reg;

    logic [CW-1:0] p_reg, q_reg;
    logic [SW-1:0] rd_first_reg, rd_second_reg;

    logic          held_valid_reg;
    category_t     held_cat_reg;
    logic [SW-1:0] held_first_reg, held_second_reg;

    logic          m_valid_reg;
    category_t     m_cat_reg;
    logic [31:0]   m_first_reg, m_second_reg;
    logic          m_overflow_reg, m_last_reg;

    logic          cfg_write;
    logic          in_accept;
    logic          load_done;
    logic          out_free;
    logic          p_has, q_has, walk_end;
    logic [SW-1:0] a_masked, b_masked;
    category_t     cmp_cat;
    logic          cmp_emit, cmp_stall;
    logic          out_push;
    category_t     out_cat;
    logic [31:0]   out_first, out_second;
    logic          out_last;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_index_t'(paddr[3:2]))
            REG_COMPARE_MASK:     prdata = mask_reg;
            REG_EMIT_ONLY_FIRST:  prdata[0] = emit_first_reg;
            REG_EMIT_BOTH:        prdata[0] = emit_both_reg;
            REG_EMIT_ONLY_SECOND: prdata[0] = emit_second_reg;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg        <= '1;
            emit_first_reg  <= 1'b1;
            emit_both_reg   <= 1'b1;
            emit_second_reg <= 1'b1;
        end else if (cfg_write) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_COMPARE_MASK:     mask_reg        <= pwdata;
                REG_EMIT_ONLY_FIRST:  emit_first_reg  <= pwdata[0];
                REG_EMIT_BOTH:        emit_both_reg   <= pwdata[0];
                REG_EMIT_ONLY_SECOND: emit_second_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign s_ready   = (state_reg == ST_LOAD);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // transaction that completes the second of the two lists starts the walk
    assign load_done = in_accept && s_list_last &&
                       ((!s_list_select && !first_done_reg && second_done_reg) ||
                        ( s_list_select && !second_done_reg && first_done_reg));

    assign p_has    = (p_reg < first_count_reg);
    assign q_has    = (q_reg < second_count_reg);
    assign walk_end = !p_has && !q_has;

    assign a_masked = rd_first_reg  & mask_reg[SW-1:0];
    assign b_masked = rd_second_reg & mask_reg[SW-1:0];

    always_comb begin
        if (!p_has) begin
            cmp_cat = CAT_ONLY_SECOND;
        end else if (!q_has) begin
            cmp_cat = CAT_ONLY_FIRST;
        end else if (a_masked < b_masked) begin
            cmp_cat = CAT_ONLY_FIRST;
        end else if (a_masked == b_masked) begin
            cmp_cat = CAT_BOTH;
        end else begin
            cmp_cat = CAT_ONLY_SECOND;
        end
    end

    always_comb begin
        case (cmp_cat)
            CAT_ONLY_FIRST:  cmp_emit = emit_first_reg;
            CAT_BOTH:        cmp_emit = emit_both_reg;
            CAT_ONLY_SECOND: cmp_emit = emit_second_reg;
            default:         cmp_emit = 1'b0;
        endcase
    end

    // a new result displaces the held one, which needs a free output slot
    assign cmp_stall = cmp_emit && held_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (load_done) state_next = ST_READ;
            ST_READ:  state_next = walk_end ? ST_FLUSH : ST_CMP;
            ST_CMP:   if (!cmp_stall) state_next = ST_READ;
            ST_FLUSH: if (out_free) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // output push: held result on displacement, or the closing result on flush
    always_comb begin
        out_push   = 1'b0;
        out_cat    = held_cat_reg;
        out_first  = '0;
        out_second = '0;
        out_last   = 1'b0;
        out_first[SW-1:0]  = held_first_reg;
        out_second[SW-1:0] = held_second_reg;
        if (state_reg == ST_CMP) begin
            out_push = cmp_emit && held_valid_reg && out_free;
        end else if (state_reg == ST_FLUSH) begin
            out_push = out_free;
            out_last = 1'b1;
            if (!held_valid_reg) begin
                out_cat    = CAT_EMPTY;
                out_first  = '0;
                out_second = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_done_reg   <= 1'b0;
            second_done_reg  <= 1'b0;
            dropped_reg      <= 1'b0;
            p_reg            <= '0;
            q_reg            <= '0;
            held_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (in_accept) begin
                if (!s_list_select && !first_done_reg) begin
                    if (s_has_key) begin
                        if (first_count_reg < DEPTH_C) begin
                            first_count_reg <= first_count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    if (s_list_last) first_done_reg <= 1'b1;
                end else if (s_list_select && !second_done_reg) begin
                    if (s_has_key) begin
                        if (second_count_reg < DEPTH_C) begin
                            second_count_reg <= second_count_reg + 1'b1;
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    if (s_list_last) second_done_reg <= 1'b1;
                end
            end

            if (state_reg == ST_CMP && !cmp_stall) begin
                if (cmp_cat != CAT_ONLY_SECOND) p_reg <= p_reg + 1'b1;
                if (cmp_cat != CAT_ONLY_FIRST)  q_reg <= q_reg + 1'b1;
                if (cmp_emit) held_valid_reg <= 1'b1;
            end

            if (state_reg == ST_FLUSH && out_free) begin
                held_valid_reg   <= 1'b0;
                first_count_reg  <= '0;
                second_count_reg <= '0;
                first_done_reg   <= 1'b0;
                second_done_reg  <= 1'b0;
                dropped_reg      <= 1'b0;
                p_reg            <= '0;
                q_reg            <= '0;
            end

            if (out_push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- list storage and datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (in_accept && s_has_key) begin
            if (!s_list_select && !first_done_reg && first_count_reg < DEPTH_C) begin
                first_list_reg[first_count_reg[IW-1:0]] <= s_key_in[SW-1:0];
            end
            if (s_list_select && !second_done_reg && second_count_reg < DEPTH_C) begin
                second_list_reg[second_count_reg[IW-1:0]] <= s_key_in[SW-1:0];
            end
        end
        if (state_reg == ST_READ) begin
            rd_first_reg  <= first_list_reg[p_reg[IW-1:0]];
            rd_second_reg <= second_list_reg[q_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CMP && cmp_emit && !cmp_stall) begin
            held_cat_reg    <= cmp_cat;
            held_first_reg  <= (cmp_cat == CAT_ONLY_SECOND) ? '0 : rd_first_reg;
            held_second_reg <= (cmp_cat == CAT_ONLY_FIRST)  ? '0 : rd_second_reg;
        end
        if (out_push) begin
            m_cat_reg      <= out_cat;
            m_first_reg    <= out_first;
            m_second_reg   <= out_second;
            m_overflow_reg <= dropped_reg;
            m_last_reg     <= out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_category   = m_cat_reg;
    assign m_key_first  = m_first_reg;
    assign m_key_second = m_second_reg;
    assign m_overflow   = m_overflow_reg;
    assign m_last       = m_last_reg;

    // ---------------- assertions ----------------
    a_counts_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_count_reg <= DEPTH_C) && (second_count_reg <= DEPTH_C))
        else $error("list count beyond depth");

    a_no_held_while_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !held_valid_reg)
        else $error("held result left over from previous run");

    a_empty_marker_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_category == CAT_EMPTY) |->
            (m_last && m_key_first == '0 && m_key_second == '0))
        else $error("empty marker malformed");

    a_flush_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && out_free) |=>
            (first_count_reg == '0 && second_count_reg == '0 &&
             !first_done_reg && !second_done_reg && m_valid && m_last))
        else $error("run not closed after flush");

endmodule

@@ test/tb.sv @@
// Testbench for sorted_merge_join_classifier_unit: list loading, merge join walk and filters.
`timescale 1ns / 1ps

module tb;
    import smjc_pkg::*;

    localparam int  LIST_DEPTH = 32;
    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    typedef struct packed {
        logic [31:0] key;
        logic        sel;
        logic        has;
        logic        fin;
    } load_item_t;

    typedef struct packed {
        category_t   cat;
        logic [31:0] key_first;
        logic [31:0] key_second;
        logic        overflow;
        logic        last;
    } join_result_t;

    typedef struct packed {
        load_item_t   item;
        logic         typed;
        join_result_t want;
    } directed_row_t;

    localparam join_result_t NO_TYPED = '{CAT_ONLY_FIRST, 32'd0, 32'd0, 1'b0, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [OUT_KEY_W-1:0] s_key_in;
    logic        s_list_select;
    logic        s_has_key;
    logic        s_list_last;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_category;
    logic [OUT_KEY_W-1:0] m_key_first;
    logic [OUT_KEY_W-1:0] m_key_second;
    logic        m_overflow;
    logic        m_last;

    sorted_merge_join_classifier_unit #(
        .LIST_DEPTH(LIST_DEPTH),
        .KEY_WIDTH (32)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_in     (s_key_in),
        .s_list_select(s_list_select),
        .s_has_key    (s_has_key),
        .s_list_last  (s_list_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_category   (m_category),
        .m_key_first  (m_key_first),
        .m_key_second (m_key_second),
        .m_overflow   (m_overflow),
        .m_last       (m_last)
    );

    // join predictor state
    logic [31:0] held_first  [LIST_DEPTH];
    logic [31:0] held_second [LIST_DEPTH];
    int unsigned cnt_first    = 0;
    int unsigned cnt_second   = 0;
    logic        closed_first  = 1'b0;
    logic        closed_second = 1'b0;
    logic        spill_seen    = 1'b0;
    logic [31:0] cmp_mask      = 32'hFFFF_FFFF;
    logic        show_only_first  = 1'b1;
    logic        show_both        = 1'b1;
    logic        show_only_second = 1'b1;

    join_result_t step_results [$];
    join_result_t pending_matches [$];
    join_result_t want;
    logic [31:0]  run_first [$];
    logic [31:0]  run_second [$];
    load_item_t   run_items [$];

    int errors        = 0;
    int items_loaded  = 0;
    int runs_sent     = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int long_hold_req = 0;

    directed_row_t directed_rows [20] = '{
        // both lists empty
        '{'{32'h0000_0000, SEL_FIRST,  1'b0, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h0000_0000, SEL_SECOND, 1'b0, 1'b1}, 1'b1,
          '{CAT_EMPTY, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}},
        // all-ones key in both lists
        '{'{32'hFFFF_FFFF, SEL_FIRST,  1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'hFFFF_FFFF, SEL_SECOND, 1'b1, 1'b1}, 1'b1,
          '{CAT_BOTH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1}},
        // zero key, then a transaction to the already closed first list
        '{'{32'h0000_0000, SEL_FIRST,  1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h0000_0005, SEL_FIRST,  1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h0000_0000, SEL_SECOND, 1'b0, 1'b1}, 1'b1,
          '{CAT_ONLY_FIRST, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}},
        // only the second list holds a key
        '{'{32'h0000_0000, SEL_FIRST,  1'b0, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h8000_0000, SEL_SECOND, 1'b1, 1'b1}, 1'b1,
          '{CAT_ONLY_SECOND, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b1}},
        // interleaved lists hitting all three categories, with a no-op transaction
        '{'{32'h0000_0001, SEL_FIRST,  1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h5555_5555, SEL_SECOND, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h5555_5555, SEL_FIRST,  1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h7FFF_FFFF, SEL_SECOND, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'hAAAA_AAAA, SEL_SECOND, 1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h0000_0000, SEL_FIRST,  1'b0, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'hAAAA_AAAA, SEL_FIRST,  1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h0000_0000, SEL_SECOND, 1'b0, 1'b1}, 1'b0, NO_TYPED},
        // descending first list, walked as given
        '{'{32'h0000_0009, SEL_FIRST,  1'b1, 1'b0}, 1'b0, NO_TYPED},
        '{'{32'h0000_0004, SEL_SECOND, 1'b1, 1'b1}, 1'b0, NO_TYPED},
        '{'{32'h0000_0002, SEL_FIRST,  1'b1, 1'b1}, 1'b0, NO_TYPED}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("sorted_merge_join_classifier_unit test failed");
        $finish;
    end

    // Loads one transaction into the predicted lists; a walk fills step_results.
    function automatic void join_step(input load_item_t it);
        int unsigned p;
        int unsigned q;
        int ord;
        logic [31:0] ka;
        logic [31:0] kb;
        join_result_t r;
        step_results.delete();
        if (it.sel == SEL_FIRST) begin
            if (closed_first) return;
            if (it.has) begin
                if (cnt_first < LIST_DEPTH) begin
                    held_first[cnt_first] = it.key;
                    cnt_first++;
                end else begin
                    spill_seen = 1'b1;
                end
            end
            if (it.fin) closed_first = 1'b1;
        end else begin
            if (closed_second) return;
            if (it.has) begin
                if (cnt_second < LIST_DEPTH) begin
                    held_second[cnt_second] = it.key;
                    cnt_second++;
                end else begin
                    spill_seen = 1'b1;
                end
            end
            if (it.fin) closed_second = 1'b1;
        end
        if (it.has || it.fin) items_loaded++;
        if (!(closed_first && closed_second)) return;

        p = 0;
        q = 0;
        while (p < cnt_first || q < cnt_second) begin
            if (p >= cnt_first) begin
                ord = 1;
            end else if (q >= cnt_second) begin
                ord = -1;
            end else begin
                ka = held_first[p] & cmp_mask;
                kb = held_second[q] & cmp_mask;
                ord = (ka < kb) ? -1 : ((ka > kb) ? 1 : 0);
            end
            if (ord < 0) begin
                if (show_only_first)
                    step_results.push_back('{CAT_ONLY_FIRST, held_first[p], 32'd0,
                                             spill_seen, 1'b0});
                p++;
            end else if (ord > 0) begin
                if (show_only_second)
                    step_results.push_back('{CAT_ONLY_SECOND, 32'd0, held_second[q],
                                             spill_seen, 1'b0});
                q++;
            end else begin
                if (show_both)
                    step_results.push_back('{CAT_BOTH, held_first[p], held_second[q],
                                             spill_seen, 1'b0});
                p++;
                q++;
            end
        end
        if (step_results.size() == 0)
            step_results.push_back('{CAT_EMPTY, 32'd0, 32'd0, spill_seen, 1'b0});
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);

        cnt_first     = 0;
        cnt_second    = 0;
        closed_first  = 1'b0;
        closed_second = 1'b0;
        spill_seen    = 1'b0;
    endfunction

    task automatic send_item(input load_item_t it, input logic typed,
                             input join_result_t typed_want);
        int gap;
        int k;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_key_in      <= it.key;
        s_list_select <= it.sel;
        s_has_key     <= it.has;
        s_list_last   <= it.fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        join_step(it);
        if (typed) begin
            pending_matches.push_back(typed_want);
        end else begin
            for (k = 0; k < step_results.size(); k++)
                pending_matches.push_back(step_results[k]);
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COMPARE_MASK:     cmp_mask         = value;
            REG_EMIT_ONLY_FIRST:  show_only_first  = value[0];
            REG_EMIT_BOTH:        show_both        = value[0];
            REG_EMIT_ONLY_SECOND: show_only_second = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_filters(input logic [31:0] mask, input logic only_first,
                               input logic both, input logic only_second);
        write_reg(REG_COMPARE_MASK, mask);
        write_reg(REG_EMIT_ONLY_FIRST, {31'd0, only_first});
        write_reg(REG_EMIT_BOTH, {31'd0, both});
        write_reg(REG_EMIT_ONLY_SECOND, {31'd0, only_second});
        settings_used++;
    endtask

    // Stop offering and wait for the block to drain and finish its flush.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 29);
        if (r < 24) return $urandom_range(0, 6);
        if (r < 28) return $urandom_range(7, 16);
        if (r == 28) return LIST_DEPTH;
        return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
    endfunction

    // Builds one run: two ascending lists sharing some keys (shuffled if scramble is set),
    // interleaved at random, with no-op transactions and junk aimed at a closed list.
    task automatic build_run(input int n1, input int n2, input logic scramble);
        logic [31:0] cursor;
        logic [31:0] tmp;
        logic wide, d1, d2, end_on_key1, end_on_key2, s;
        int pick, i, j, p1, p2;
        load_item_t it;
        run_first.delete();
        run_second.delete();
        run_items.delete();
        cursor = $urandom;
        wide   = ($urandom_range(0, 3) == 0);
        while (run_first.size() < n1 || run_second.size() < n2) begin
            cursor += wide ? $urandom_range(1, 32'h0FFF_FFFF) : $urandom_range(0, 12);
            pick = (run_first.size() >= n1) ? 2 :
                   (run_second.size() >= n2) ? 0 : $urandom_range(0, 2);
            if (pick != 2) run_first.push_back(cursor);
            if (pick != 0) run_second.push_back(cursor);
        end
        if (scramble) begin
            for (i = 0; i < n1; i++) begin
                j = $urandom_range(0, n1 - 1);
                tmp = run_first[i];
                run_first[i] = run_first[j];
                run_first[j] = tmp;
            end
            for (i = 0; i < n2; i++) begin
                j = $urandom_range(0, n2 - 1);
                tmp = run_second[i];
                run_second[i] = run_second[j];
                run_second[j] = tmp;
            end
        end

        end_on_key1 = 1'($urandom);
        end_on_key2 = 1'($urandom);
        p1 = 0;
        p2 = 0;
        d1 = 1'b0;
        d2 = 1'b0;
        while (!(d1 && d2)) begin
            if ((d1 || d2) && $urandom_range(0, 7) == 0) begin
                it = '{$urandom, d1 ? SEL_FIRST : SEL_SECOND, 1'($urandom), 1'($urandom)};
            end else begin
                s = d1 ? SEL_SECOND : (d2 ? SEL_FIRST : 1'($urandom));
                if ($urandom_range(0, 15) == 0) begin
                    it = '{$urandom, s, 1'b0, 1'b0};
                end else if (s == SEL_FIRST) begin
                    if (p1 < n1) begin
                        it = '{run_first[p1], SEL_FIRST, 1'b1,
                               (p1 == n1 - 1) && end_on_key1};
                        p1++;
                    end else begin
                        it = '{$urandom, SEL_FIRST, 1'b0, 1'b1};
                    end
                    d1 = it.fin;
                end else begin
                    if (p2 < n2) begin
                        it = '{run_second[p2], SEL_SECOND, 1'b1,
                               (p2 == n2 - 1) && end_on_key2};
                        p2++;
                    end else begin
                        it = '{$urandom, SEL_SECOND, 1'b0, 1'b1};
                    end
                    d2 = it.fin;
                end
            end
            run_items.push_back(it);
        end
    endtask

    task automatic send_run();
        int i;
        for (i = 0; i < run_items.size(); i++)
            send_item(run_items[i], 1'b0, NO_TYPED);
        runs_sent++;
    endtask

    task automatic run_phase(input int target);
        int start;
        start = items_loaded;
        while (items_loaded - start < target) begin
            build_run(pick_len(), pick_len(), $urandom_range(0, 5) == 0);
            send_run();
        end
        settle();
    endtask

    // Output side: changes its stall pattern now and then; honors long hold requests.
    initial begin
        int mode;
        int span;
        int hold_left;
        int tick;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        tick      = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            tick++;
            if (long_hold_req > 0) begin
                hold_left     = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 80);
                end
                span--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                $error("unexpected result transaction: category %0d, first %h, second %h",
                       m_category, m_key_first, m_key_second);
                errors++;
            end else begin
                want = pending_matches.pop_front();
                results_seen++;
                if (m_category !== want.cat) begin
                    $error("category: expected %0d, got %0d", want.cat, m_category);
                    errors++;
                end
                if (m_key_first !== want.key_first) begin
                    $error("key_first: expected %h, got %h", want.key_first, m_key_first);
                    errors++;
                end
                if (m_key_second !== want.key_second) begin
                    $error("key_second: expected %h, got %h", want.key_second, m_key_second);
                    errors++;
                end
                if (m_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_overflow);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int i;
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_key_in      <= '0;
        s_list_select <= SEL_FIRST;
        s_has_key     <= 1'b0;
        s_list_last   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults after reset
        settings_used++;
        for (i = 0; i < $size(directed_rows); i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        settle();

        set_filters(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        build_run(LIST_DEPTH + 1, 2, 1'b0);
        send_run();
        run_phase(6);

        // zero mask: every pair compares equal
        set_filters(32'h0000_0000, 1'b1, 1'b1, 1'b1);
        run_phase(6);

        set_filters(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1);
        run_phase(6);

        set_filters($urandom, 1'b0, 1'b1, 1'b0);
        run_phase(6);

        // everything filtered: each run ends in the empty marker
        set_filters($urandom, 1'b0, 1'b0, 1'b0);
        run_phase(6);

        set_filters(32'h0000_FFFF, 1'($urandom), 1'($urandom), 1'($urandom));
        run_phase(6);

        // long output stall while the next run is already being offered
        set_filters(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        long_hold_req = 300;
        build_run(12, 12, 1'b0);
        send_run();
        build_run(3, 3, 1'b0);
        send_run();
        settle();

        repeat (20) @(posedge aclk);
        $display("Loaded %0d list items in %0d runs; %0d results checked under %0d settings.",
                 items_loaded, runs_sent, results_seen, settings_used);
        $display("Runs covered empty and full lists, overflow, unsorted keys and stalls.");
        if (errors == 0) begin
            $display("sorted_merge_join_classifier_unit test passed");
        end else begin
            $display("sorted_merge_join_classifier_unit test failed");
        end
        $finish;
    end

endmodule
